// File: sv/uclt_pkg.sv
package uclt_pkg;

  // counter sizing
  localparam int LENGTH_BITS = 16;
  localparam int CNT_W = LENGTH_BITS + 1;
  localparam int CMP_W = (CNT_W > 17) ? CNT_W : 17;
  localparam int LEN_W = 16;

  localparam logic [CNT_W-1:0] CNT_CAP = {1'b1, {LENGTH_BITS{1'b0}}};
  localparam logic [LEN_W-1:0] KEPT_MAX = 16'hFFFF;

  // utf-8 continuation byte test
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_MARK = 8'h80;

  // configuration register indexes
  localparam logic [1:0] CFG_KIND = 2'd0;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd1;
  localparam logic [1:0] CFG_STRICT = 2'd2;
  localparam logic [1:0] CFG_IGNORE = 2'd3;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_SAFE = 2'd2,
    KIND_BYTE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OUTCOME_OK = 2'd0,
    OUTCOME_WARN = 2'd1,
    OUTCOME_ERROR = 2'd2
  } outcome_t;

  typedef struct packed {
    kind_t kind;
    logic [LEN_W-1:0] max_length;
    logic strict_mode;
    logic ignore_errors;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
    logic empty_string;
  } beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] kept_length;
    logic truncated;
    outcome_t outcome;
  } result_t;

  // saturate a length to the 16-bit output range
  function automatic logic [LEN_W-1:0] clip_len(input logic [CMP_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v > CMP_W'(KEPT_MAX)) begin
      r = KEPT_MAX;
    end else begin
      r = v[LEN_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/utf8_column_length_truncator_unit.sv
// channel  signals                                         dir
// -------  ----------------------------------------------  ---
// in       in_valid in_ready data_byte last_byte empty_string in
// out      out_valid out_ready kept_length truncated outcome  out
// cfg      cfg_valid cfg_ready cfg_index cfg_data            in
//
// one byte per cycle sustained; a byte is accepted every cycle while the
// result register is free or being drained
// a string-ending beat is registered in the input stage, then its result is loaded
// into the result register, held back while that register is full and not drained
// rst (synchronous) clears config, counters and both valid flags
// a stalled result only holds back a string-ending beat and the beats behind it
module utf8_column_length_truncator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] kept_length,
  output logic        truncated,
  output logic [1:0]  outcome,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  uclt_pkg::cfg_t cfg;
  uclt_pkg::beat_t in_beat, s_beat;
  uclt_pkg::result_t res, res_out;
  logic s_valid, advance, res_load, out_free;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind <= uclt_pkg::KIND_NONE;
      cfg.max_length <= '0;
      cfg.strict_mode <= 1'b0;
      cfg.ignore_errors <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        uclt_pkg::CFG_KIND: cfg.kind <= uclt_pkg::kind_t'(cfg_data[1:0]);
        uclt_pkg::CFG_MAX_LENGTH: cfg.max_length <= cfg_data;
        uclt_pkg::CFG_STRICT: cfg.strict_mode <= cfg_data[0];
        uclt_pkg::CFG_IGNORE: cfg.ignore_errors <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_beat.data_byte = data_byte;
  assign in_beat.last_byte = last_byte;
  assign in_beat.empty_string = empty_string;

  uclt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .advance  (advance),
    .s_valid  (s_valid),
    .s_beat   (s_beat)
  );

  uclt_tracker u_track (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_valid  (s_valid),
    .s_beat   (s_beat),
    .out_free (out_free),
    .advance  (advance),
    .res_load (res_load),
    .res      (res)
  );

  uclt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_in    (res),
    .out_ready (out_ready),
    .out_free  (out_free),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign kept_length = res_out.kept_length;
  assign truncated = res_out.truncated;
  assign outcome = res_out.outcome;

  // outcome agrees with the truncation flag
  a_ok_when_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !truncated) |-> outcome == uclt_pkg::OUTCOME_OK)
    else $error("non-ok outcome without truncation");

  a_flag_when_bad: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> outcome != uclt_pkg::OUTCOME_OK)
    else $error("truncation reported as ok");

  // a result is never overwritten while waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result register overwritten");

endmodule

// File: sv/uclt_in_stage.sv
module uclt_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  uclt_pkg::beat_t in_beat,
  input  logic            advance,
  output logic            s_valid,
  output uclt_pkg::beat_t s_beat
);

  logic accept;

  // stage frees up when its beat moves on
  assign in_ready = !s_valid || advance;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      s_beat <= in_beat;
    end
  end

endmodule

// File: sv/uclt_tracker.sv
module uclt_tracker (
  input  logic              clk,
  input  logic              rst,
  input  uclt_pkg::cfg_t    cfg,
  input  logic              s_valid,
  input  uclt_pkg::beat_t   s_beat,
  input  logic              out_free,
  output logic              advance,
  output logic              res_load,
  output uclt_pkg::result_t res
);

  logic [uclt_pkg::CNT_W-1:0] bytes_seen, bytes_seen_next;
  logic [uclt_pkg::CNT_W-1:0] leads_seen, leads_seen_next;
  logic [uclt_pkg::LEN_W-1:0] cut_position, cut_position_next;
  logic cut_found, cut_found_next;

  logic ends;
  logic lead;
  logic trunc;
  logic [uclt_pkg::CMP_W-1:0] pos_w, lim_w, bytes_w, kept_w;

  // a beat that ends a string needs room in the result register
  assign ends = s_beat.last_byte || s_beat.empty_string;
  assign advance = s_valid && (!ends || out_free);
  assign res_load = advance && ends;

  // per-byte counter update
  always_comb begin
    lead = (s_beat.data_byte & uclt_pkg::CONT_MASK) != uclt_pkg::CONT_MARK;
    pos_w = uclt_pkg::CMP_W'(bytes_seen);
    lim_w = uclt_pkg::CMP_W'(cfg.max_length);
    bytes_seen_next = bytes_seen;
    leads_seen_next = leads_seen;
    cut_position_next = cut_position;
    cut_found_next = cut_found;
    if (lead && cfg.kind == uclt_pkg::KIND_CHAR) begin
      if (!cut_found && uclt_pkg::CMP_W'(leads_seen) == lim_w) begin
        cut_found_next = 1'b1;
        cut_position_next = uclt_pkg::clip_len(pos_w);
      end
      if (leads_seen < uclt_pkg::CNT_CAP) begin
        leads_seen_next = leads_seen + 1'b1;
      end
    end else if (lead && cfg.kind == uclt_pkg::KIND_SAFE) begin
      if (pos_w <= lim_w) begin
        cut_position_next = uclt_pkg::clip_len(pos_w);
      end
    end
    if (bytes_seen < uclt_pkg::CNT_CAP) begin
      bytes_seen_next = bytes_seen + 1'b1;
    end
  end

  // end-of-string verdict from the updated counters
  always_comb begin
    bytes_w = uclt_pkg::CMP_W'(bytes_seen_next);
    case (cfg.kind)
      uclt_pkg::KIND_CHAR: begin
        trunc = cut_found_next;
        kept_w = trunc ? uclt_pkg::CMP_W'(cut_position_next) : bytes_w;
      end
      uclt_pkg::KIND_SAFE: begin
        trunc = bytes_w > lim_w;
        kept_w = trunc ? uclt_pkg::CMP_W'(cut_position_next) : bytes_w;
      end
      uclt_pkg::KIND_BYTE: begin
        trunc = bytes_w > lim_w;
        kept_w = trunc ? lim_w : bytes_w;
      end
      default: begin
        trunc = 1'b0;
        kept_w = bytes_w;
      end
    endcase
    if (s_beat.empty_string) begin
      res.kept_length = '0;
      res.truncated = 1'b0;
      res.outcome = uclt_pkg::OUTCOME_OK;
    end else begin
      res.kept_length = uclt_pkg::clip_len(kept_w);
      res.truncated = trunc;
      if (!trunc) begin
        res.outcome = uclt_pkg::OUTCOME_OK;
      end else if (cfg.strict_mode && !cfg.ignore_errors) begin
        res.outcome = uclt_pkg::OUTCOME_ERROR;
      end else begin
        res.outcome = uclt_pkg::OUTCOME_WARN;
      end
    end
  end

  // string state, cleared at every string end
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      leads_seen <= '0;
      cut_position <= '0;
      cut_found <= 1'b0;
    end else if (advance) begin
      if (ends) begin
        bytes_seen <= '0;
        leads_seen <= '0;
        cut_position <= '0;
        cut_found <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen_next;
        leads_seen <= leads_seen_next;
        cut_position <= cut_position_next;
        cut_found <= cut_found_next;
      end
    end
  end

  // counters never pass the cap
  a_bytes_cap: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= uclt_pkg::CNT_CAP)
    else $error("byte counter beyond cap");

  // every lead counted is also a byte counted
  a_leads_le_bytes: assert property (@(posedge clk) disable iff (rst)
    leads_seen <= bytes_seen)
    else $error("lead count exceeds byte count");

  // the cut mark is set only together with a counted lead
  a_cut_has_lead: assert property (@(posedge clk) disable iff (rst)
    cut_found |-> leads_seen != '0)
    else $error("cut found with no lead counted");

  // a string end leaves clean state behind
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (bytes_seen == '0 && leads_seen == '0 && !cut_found))
    else $error("state not cleared after string end");

endmodule

// File: sv/uclt_out_stage.sv
module uclt_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  uclt_pkg::result_t res_in,
  input  logic              out_ready,
  output logic              out_free,
  output logic              out_valid,
  output uclt_pkg::result_t res_out
);

  // register can take a new result when empty or being drained
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
